// ===== rtl/fps_pkg.sv =====
// ----------------------------------------------------------------------------
// fps_pkg
// Shared constants, word types and control structs of the farthest point
// sampler.
// ----------------------------------------------------------------------------
package fps_pkg;

  localparam int MAX_POINTS  = 1024;
  localparam int MAX_SAMPLES = 64;
  localparam int COORD_W     = 16;
  localparam int IDX_W       = $clog2(MAX_POINTS);
  localparam int CNT_W       = $clog2(MAX_POINTS + 1);
  localparam int SCNT_W      = 7;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int DIST_W      = 2 * COORD_W + 2;
  localparam int POINT_W     = 3 * COORD_W;
  localparam int OUT_IDX_W   = 10;

  localparam logic [DIST_W-1:0] DIST_ONES = '1;

  typedef struct packed {
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic                      last_point;
  } in_word_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] sample_index;
    logic                 last_sample;
  } out_word_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_EMIT,
    ST_REF,
    ST_SWEEP,
    ST_WAIT
  } state_t;

  // read issued to both stores this cycle
  typedef struct packed {
    logic             valid;
    logic             last;
    logic             first;
    logic             ref_rd;
    logic [IDX_W-1:0] idx;
  } sweep_ctl_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [DIST_W-1:0] data;
  } dist_wr_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] best;
  } sweep_res_t;

endpackage

// ===== rtl/fps_ram.sv =====
// ----------------------------------------------------------------------------
// fps_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/fps_sweep.sv =====
// ----------------------------------------------------------------------------
// fps_sweep
// Distance pipeline: difference, square, sum and minimum update, then a
// running maximum over the updated minima.
// ----------------------------------------------------------------------------
module fps_sweep (
  input  logic                   clk,
  input  logic                   rst,
  input  fps_pkg::sweep_ctl_t    ctl,
  input  fps_pkg::point_t        coord_rdata,
  input  logic [fps_pkg::DIST_W-1:0] dist_rdata,
  output fps_pkg::dist_wr_t      dist_wr,
  output fps_pkg::sweep_res_t    res
);

  fps_pkg::sweep_ctl_t s0;
  fps_pkg::point_t     ref_pt;

  logic                               s1_v, s1_last;
  logic [fps_pkg::IDX_W-1:0]          s1_idx;
  logic signed [fps_pkg::DIFF_W-1:0]  s1_dx, s1_dy, s1_dz;
  logic [fps_pkg::DIST_W-1:0]         s1_old;

  logic                               s2_v, s2_last;
  logic [fps_pkg::IDX_W-1:0]          s2_idx;
  logic [fps_pkg::DIST_W-1:0]         s2_sqx, s2_sqy, s2_sqz, s2_old;

  logic                               s3_v, s3_last;
  logic [fps_pkg::IDX_W-1:0]          s3_idx;
  logic [fps_pkg::DIST_W-1:0]         s3_min;

  logic [fps_pkg::DIST_W-1:0]         best_d;
  logic [fps_pkg::IDX_W-1:0]          best_idx;
  logic                               done;

  logic signed [fps_pkg::DIST_W-1:0]  ex, ey, ez;
  logic [fps_pkg::DIST_W-1:0]         sum;
  logic                               take;

  assign ex = {{(fps_pkg::DIST_W - fps_pkg::DIFF_W){s1_dx[fps_pkg::DIFF_W-1]}}, s1_dx};
  assign ey = {{(fps_pkg::DIST_W - fps_pkg::DIFF_W){s1_dy[fps_pkg::DIFF_W-1]}}, s1_dy};
  assign ez = {{(fps_pkg::DIST_W - fps_pkg::DIFF_W){s1_dz[fps_pkg::DIFF_W-1]}}, s1_dz};

  // the sum of three squares never reaches all ones
  assign sum = s2_sqx + s2_sqy + s2_sqz;

  assign dist_wr.en   = s2_v;
  assign dist_wr.addr = s2_idx;
  assign dist_wr.data = (sum < s2_old) ? sum : s2_old;

  // entry zero opens every sweep, so it seeds the maximum
  assign take = (s3_idx == '0) || (s3_min > best_d);

  assign res.done = done;
  assign res.best = best_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0.valid  <= 1'b0;
      s0.ref_rd <= 1'b0;
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      done      <= 1'b0;
    end else begin
      s0.valid  <= ctl.valid;
      s0.ref_rd <= ctl.ref_rd;
      s1_v      <= s0.valid;
      s2_v      <= s1_v;
      s3_v      <= s2_v;
      done      <= s3_v && s3_last;
    end
    s0.last  <= ctl.last;
    s0.first <= ctl.first;
    s0.idx   <= ctl.idx;

    if (s0.ref_rd) begin
      ref_pt <= coord_rdata;
    end

    s1_last <= s0.last;
    s1_idx  <= s0.idx;
    s1_dx   <= {coord_rdata.x[fps_pkg::COORD_W-1], coord_rdata.x}
             - {ref_pt.x[fps_pkg::COORD_W-1], ref_pt.x};
    s1_dy   <= {coord_rdata.y[fps_pkg::COORD_W-1], coord_rdata.y}
             - {ref_pt.y[fps_pkg::COORD_W-1], ref_pt.y};
    s1_dz   <= {coord_rdata.z[fps_pkg::COORD_W-1], coord_rdata.z}
             - {ref_pt.z[fps_pkg::COORD_W-1], ref_pt.z};
    // first sweep of a cloud: the store still holds stale minima
    s1_old  <= s0.first ? fps_pkg::DIST_ONES : dist_rdata;

    s2_last <= s1_last;
    s2_idx  <= s1_idx;
    s2_sqx  <= ex * ex;
    s2_sqy  <= ey * ey;
    s2_sqz  <= ez * ez;
    s2_old  <= s1_old;

    s3_last <= s2_last;
    s3_idx  <= s2_idx;
    s3_min  <= dist_wr.data;

    if (s3_v && take) begin
      best_d   <= s3_min;
      best_idx <= s3_idx;
    end
  end

endmodule

// ===== rtl/farthest_point_sampler.sv =====
// ----------------------------------------------------------------------------
// farthest_point_sampler
// Farthest point sampling over a loaded 3D point cloud.
// ----------------------------------------------------------------------------
// Points load at one word per cycle into a coordinate RAM; the word marked
// last_point closes the cloud. Index 0 is emitted first; each further index
// costs one sweep over the n loaded points through a single read port of the
// coordinate and distance RAMs, one point per cycle, plus reference read and
// pipeline drain. The distance RAM needs no clearing pass: the first sweep
// of a cloud ignores its old contents. A waiting output word does not stall
// loading.
module farthest_point_sampler (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  fps_pkg::in_word_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output fps_pkg::out_word_t                out_data,
  input  logic                              cfg_wr_en,
  input  logic [fps_pkg::SCNT_W-1:0]        cfg_wr_data
);

  fps_pkg::state_t             state, state_next;
  logic [fps_pkg::CNT_W-1:0]   count, count_next;
  logic [fps_pkg::IDX_W-1:0]   nlast, nlast_next;
  logic [fps_pkg::SCNT_W-1:0]  target, target_next;
  logic [fps_pkg::SCNT_W-1:0]  s_cnt, s_cnt_next;
  logic [fps_pkg::IDX_W-1:0]   sel, sel_next;
  logic                        first, first_next;
  logic [fps_pkg::IDX_W-1:0]   iss_idx, iss_idx_next;
  logic                        out_valid_next;
  fps_pkg::out_word_t          out_data_next;
  logic [fps_pkg::SCNT_W-1:0]  sample_count;
  logic [fps_pkg::SCNT_W-1:0]  clamped;

  logic                        in_acc, room;
  logic                        coord_we;
  logic [fps_pkg::IDX_W-1:0]   coord_raddr;
  logic [fps_pkg::POINT_W-1:0] coord_rdata;
  fps_pkg::point_t             wr_pt;
  logic [fps_pkg::DIST_W-1:0]  dist_rdata;
  fps_pkg::sweep_ctl_t         ctl;
  fps_pkg::dist_wr_t           dist_wr;
  fps_pkg::sweep_res_t         res;

  assign in_ready = (state == fps_pkg::ST_LOAD);
  assign in_acc   = in_valid && in_ready;
  assign room     = (count < fps_pkg::CNT_W'(fps_pkg::MAX_POINTS));
  assign coord_we = in_acc && room;

  assign wr_pt.x = in_data.coord_x;
  assign wr_pt.y = in_data.coord_y;
  assign wr_pt.z = in_data.coord_z;

  assign clamped = (sample_count == '0) ? fps_pkg::SCNT_W'(1) :
                   (sample_count > fps_pkg::SCNT_W'(fps_pkg::MAX_SAMPLES)) ?
                   fps_pkg::SCNT_W'(fps_pkg::MAX_SAMPLES) : sample_count;

  assign coord_raddr = (state == fps_pkg::ST_REF) ? sel : iss_idx;

  assign ctl.valid  = (state == fps_pkg::ST_SWEEP);
  assign ctl.last   = (iss_idx == nlast);
  assign ctl.first  = first;
  assign ctl.ref_rd = (state == fps_pkg::ST_REF);
  assign ctl.idx    = iss_idx;

  fps_ram #(
    .WIDTH (fps_pkg::POINT_W),
    .DEPTH (fps_pkg::MAX_POINTS)
  ) u_coord_ram (
    .clk   (clk),
    .we    (coord_we),
    .waddr (count[fps_pkg::IDX_W-1:0]),
    .wdata (wr_pt),
    .raddr (coord_raddr),
    .rdata (coord_rdata)
  );

  fps_ram #(
    .WIDTH (fps_pkg::DIST_W),
    .DEPTH (fps_pkg::MAX_POINTS)
  ) u_dist_ram (
    .clk   (clk),
    .we    (dist_wr.en),
    .waddr (dist_wr.addr),
    .wdata (dist_wr.data),
    .raddr (iss_idx),
    .rdata (dist_rdata)
  );

  fps_sweep u_sweep (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .coord_rdata (fps_pkg::point_t'(coord_rdata)),
    .dist_rdata  (dist_rdata),
    .dist_wr     (dist_wr),
    .res         (res)
  );

  always_comb begin
    state_next     = state;
    count_next     = count;
    nlast_next     = nlast;
    target_next    = target;
    s_cnt_next     = s_cnt;
    sel_next       = sel;
    first_next     = first;
    iss_idx_next   = iss_idx;
    out_valid_next = out_valid && !out_ready;
    out_data_next  = out_data;
    case (state)
      fps_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (room) begin
            count_next = count + fps_pkg::CNT_W'(1);
          end
          if (in_data.last_point) begin
            nlast_next  = room ? count[fps_pkg::IDX_W-1:0] :
                          fps_pkg::IDX_W'(fps_pkg::MAX_POINTS - 1);
            target_next = clamped;
            s_cnt_next  = '0;
            sel_next    = '0;
            first_next  = 1'b1;
            state_next  = fps_pkg::ST_EMIT;
          end
        end
      end
      fps_pkg::ST_EMIT: begin
        if (!out_valid || out_ready) begin
          out_valid_next             = 1'b1;
          out_data_next.sample_index = fps_pkg::OUT_IDX_W'(sel);
          out_data_next.last_sample  = (fps_pkg::SCNT_W'(s_cnt + 1'b1) == target);
          s_cnt_next                 = s_cnt + 1'b1;
          if (fps_pkg::SCNT_W'(s_cnt + 1'b1) == target) begin
            count_next = '0;
            state_next = fps_pkg::ST_LOAD;
          end else begin
            state_next = fps_pkg::ST_REF;
          end
        end
      end
      fps_pkg::ST_REF: begin
        iss_idx_next = '0;
        state_next   = fps_pkg::ST_SWEEP;
      end
      fps_pkg::ST_SWEEP: begin
        iss_idx_next = iss_idx + 1'b1;
        if (iss_idx == nlast) begin
          state_next = fps_pkg::ST_WAIT;
        end
      end
      fps_pkg::ST_WAIT: begin
        // hold until the last point leaves the maximum stage
        if (res.done) begin
          sel_next   = res.best;
          first_next = 1'b0;
          state_next = fps_pkg::ST_EMIT;
        end
      end
      default: begin
        state_next = fps_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= fps_pkg::ST_LOAD;
      count        <= '0;
      s_cnt        <= '0;
      out_valid    <= 1'b0;
      sample_count <= fps_pkg::SCNT_W'(1);
    end else begin
      state     <= state_next;
      count     <= count_next;
      s_cnt     <= s_cnt_next;
      out_valid <= out_valid_next;
      if (cfg_wr_en) begin
        sample_count <= cfg_wr_data;
      end
    end
    nlast    <= nlast_next;
    target   <= target_next;
    sel      <= sel_next;
    first    <= first_next;
    iss_idx  <= iss_idx_next;
    out_data <= out_data_next;
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    res.done |-> (state == fps_pkg::ST_WAIT))
    else $error("sweep finished outside wait state");

  a_wr_in_cloud: assert property (@(posedge clk) disable iff (rst)
    dist_wr.en |-> (dist_wr.addr <= nlast))
    else $error("distance write beyond loaded points");

  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    (state != fps_pkg::ST_LOAD) |-> (s_cnt < target))
    else $error("emitted more indices than requested");

  a_sweep_one_point: assert property (@(posedge clk) disable iff (rst)
    (state == fps_pkg::ST_SWEEP) |=> (in_ready == 1'b0))
    else $error("input accepted during sweep");

endmodule

// ===== dv/farthest_point_sampler_test.sv =====
// ----------------------------------------------------------------------------
// farthest_point_sampler_test
// Self-checking bench for the farthest point sampler. Point clouds are
// streamed in over the input channel and every emitted sample index is
// compared with a cycle-free prediction of the sampling order. Directed
// clouds cover the coordinate extremes, ties, the sample count limits and
// cloud overflow. Random clouds then run under mixed idle and stall patterns.
// ----------------------------------------------------------------------------
module farthest_point_sampler_test;

  localparam int QUIET_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 32;
  localparam int REPORT_MAX    = 10;

  typedef enum int {SPREAD, CLUSTER, CORNER} coord_style_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  fps_pkg::in_word_t          in_data = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  fps_pkg::out_word_t         out_data;
  logic                       cfg_wr_en = 1'b0;
  logic [fps_pkg::SCNT_W-1:0] cfg_wr_data = '0;

  // predicted sampler state
  logic signed [fps_pkg::COORD_W-1:0] px [fps_pkg::MAX_POINTS];
  logic signed [fps_pkg::COORD_W-1:0] py [fps_pkg::MAX_POINTS];
  logic signed [fps_pkg::COORD_W-1:0] pz [fps_pkg::MAX_POINTS];
  logic [fps_pkg::DIST_W-1:0]         nearest_sq [fps_pkg::MAX_POINTS];
  int unsigned                        stored_pts = 0;
  logic [fps_pkg::SCNT_W-1:0]         sample_count_cfg = fps_pkg::SCNT_W'(1);
  fps_pkg::out_word_t                 expected_picks [$];

  int send_gap_pct = 0;
  int stall_pct    = 0;
  int mismatches   = 0;
  int points_sent  = 0;
  int clouds_closed = 0;
  int results_seen = 0;
  int quiet_cycles = 0;

  farthest_point_sampler dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Store one point and, on the closing point, work out the whole index order.
  function automatic void predict_picks(input fps_pkg::in_word_t w);
    int unsigned n, cnt, pick, best, s, i;
    longint dx, dy, dz;
    logic [fps_pkg::DIST_W-1:0] d, best_d;
    fps_pkg::out_word_t r;
    if (stored_pts < fps_pkg::MAX_POINTS) begin
      px[stored_pts] = w.coord_x;
      py[stored_pts] = w.coord_y;
      pz[stored_pts] = w.coord_z;
      stored_pts++;
    end
    if (w.last_point) begin
      n = stored_pts;
      for (i = 0; i < n; i++) nearest_sq[i] = fps_pkg::DIST_ONES;
      cnt = 32'(sample_count_cfg);
      if (cnt == 0) cnt = 1;
      if (cnt > fps_pkg::MAX_SAMPLES) cnt = fps_pkg::MAX_SAMPLES;
      pick = 0;
      for (s = 0; s < cnt; s++) begin
        r.sample_index = fps_pkg::OUT_IDX_W'(pick);
        r.last_sample  = (s + 1 == cnt);
        expected_picks.push_back(r);
        if (s + 1 == cnt) break;
        // lower every minimum to the distance from the point just emitted
        for (i = 0; i < n; i++) begin
          dx = longint'(px[i]) - longint'(px[pick]);
          dy = longint'(py[i]) - longint'(py[pick]);
          dz = longint'(pz[i]) - longint'(pz[pick]);
          d  = fps_pkg::DIST_W'(dx * dx + dy * dy + dz * dz);
          if (d < nearest_sq[i]) nearest_sq[i] = d;
        end
        // strict compare keeps the lowest index on a tie
        best = 0;
        best_d = nearest_sq[0];
        for (i = 1; i < n; i++) begin
          if (nearest_sq[i] > best_d) begin
            best_d = nearest_sq[i];
            best = i;
          end
        end
        pick = best;
      end
      stored_pts = 0;
      clouds_closed++;
    end
  endfunction

  function automatic fps_pkg::in_word_t mk_point(input int x, input int y, input int z,
                                                 input bit last);
    fps_pkg::in_word_t w;
    w.coord_x    = fps_pkg::COORD_W'(x);
    w.coord_y    = fps_pkg::COORD_W'(y);
    w.coord_z    = fps_pkg::COORD_W'(z);
    w.last_point = last;
    return w;
  endfunction

  function automatic int rand_coord(input coord_style_t style);
    int corners [5];
    corners = '{-32768, -1, 0, 1, 32767};
    case (style)
      CLUSTER: return int'($urandom_range(6)) - 3;
      CORNER:  return ($urandom_range(3) == 0) ? int'($urandom_range(65535)) - 32768
                                               : corners[$urandom_range(4)];
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  // The word is committed once valid rises, so predict it there.
  task automatic push_point(input fps_pkg::in_word_t w);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    predict_picks(w);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    points_sent++;
  endtask

  // Drop valid, wait for every expected index, then let the block go idle.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (expected_picks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_sample_count(input logic [fps_pkg::SCNT_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sample_count_cfg = v;
  endtask

  always @(posedge clk) begin : check_picks
    fps_pkg::out_word_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_picks.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected word: sample_index %0d last_sample %0b",
                   out_data.sample_index, out_data.last_sample);
      end else begin
        want = expected_picks.pop_front();
        if (out_data.sample_index !== want.sample_index ||
            out_data.last_sample !== want.last_sample) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("mismatch: expected index %0d last %0b, got index %0d last %0b",
                     want.sample_index, want.last_sample,
                     out_data.sample_index, out_data.last_sample);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles, %0d indices outstanding",
               quiet_cycles, expected_picks.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Sample count left at its reset value: one index per cloud.
  task automatic test_reset_count();
    push_point(mk_point(-32768, 32767, 0, 1'b0));
    push_point(mk_point(32767, -32768, -1, 1'b0));
    push_point(mk_point(0, 0, 0, 1'b1));
    settle_block();
  endtask

  // Full-scale coordinates at the largest sample count.
  task automatic test_extremes();
    write_sample_count(fps_pkg::SCNT_W'(fps_pkg::MAX_SAMPLES));
    push_point(mk_point(-32768, -32768, -32768, 1'b0));
    push_point(mk_point(32767, 32767, 32767, 1'b0));
    push_point(mk_point(0, 0, 0, 1'b0));
    push_point(mk_point(-32768, 32767, -1, 1'b0));
    push_point(mk_point(1, -2, 32767, 1'b1));
    settle_block();
  endtask

  // A count of zero acts as one; counts above the maximum clamp to it.
  task automatic test_count_limits();
    write_sample_count(fps_pkg::SCNT_W'(0));
    push_point(mk_point(100, -100, 5, 1'b0));
    push_point(mk_point(-7, 9, 32767, 1'b1));
    settle_block();
    write_sample_count(fps_pkg::SCNT_W'(127));
    push_point(mk_point(-12345, 23456, -32768, 1'b1));
    settle_block();
    write_sample_count(fps_pkg::SCNT_W'(fps_pkg::MAX_SAMPLES + 1));
    push_point(mk_point(3, 3, 3, 1'b0));
    push_point(mk_point(-3, -3, -3, 1'b1));
    settle_block();
  endtask

  // Equal distances must resolve to the lowest index.
  task automatic test_ties();
    write_sample_count(fps_pkg::SCNT_W'(5));
    repeat (3) push_point(mk_point(7, -7, 7, 1'b0));
    push_point(mk_point(7, -7, 7, 1'b1));
    settle_block();
    push_point(mk_point(0, 0, 0, 1'b0));
    push_point(mk_point(5, 0, 0, 1'b0));
    push_point(mk_point(-5, 0, 0, 1'b0));
    push_point(mk_point(0, 3, 4, 1'b1));
    settle_block();
  endtask

  // Overfill the store: surplus points, the closing one too, are dropped.
  task automatic test_overflow();
    int i;
    write_sample_count(fps_pkg::SCNT_W'(4));
    for (i = 0; i < fps_pkg::MAX_POINTS + 6; i++) begin
      if (i == 0)
        push_point(mk_point(-32768, -32768, -32768, 1'b0));
      else if (i == fps_pkg::MAX_POINTS - 1)
        push_point(mk_point(32767, 32767, 32767, 1'b0));
      else if (i < fps_pkg::MAX_POINTS)
        push_point(mk_point(rand_coord(CLUSTER), rand_coord(CLUSTER),
                            rand_coord(CLUSTER), 1'b0));
      else
        push_point(mk_point(rand_coord(SPREAD), rand_coord(SPREAD),
                            rand_coord(SPREAD), i == fps_pkg::MAX_POINTS + 5));
    end
    settle_block();
  endtask

  task automatic test_random_clouds(input int gap_pct, input int hold_pct,
                                    input int budget);
    int start, n, i, clouds;
    coord_style_t style;
    logic [fps_pkg::SCNT_W-1:0] cnt;
    send_gap_pct = gap_pct;
    stall_pct    = hold_pct;
    start  = points_sent;
    clouds = 0;
    while (points_sent - start < budget) begin
      if (clouds % 4 == 0) begin
        settle_block();
        case ($urandom_range(7))
          0:       cnt = fps_pkg::SCNT_W'(0);
          1:       cnt = fps_pkg::SCNT_W'(1);
          2:       cnt = fps_pkg::SCNT_W'(fps_pkg::MAX_SAMPLES);
          3:       cnt = fps_pkg::SCNT_W'($urandom_range(127));
          default: cnt = fps_pkg::SCNT_W'($urandom_range(1, 16));
        endcase
        write_sample_count(cnt);
      end
      n = ($urandom_range(19) == 0) ? int'($urandom_range(13, 64))
                                    : int'($urandom_range(1, 12));
      style = coord_style_t'($urandom_range(2));
      for (i = 0; i < n; i++)
        push_point(mk_point(rand_coord(style), rand_coord(style), rand_coord(style),
                            i == n - 1));
      clouds++;
    end
    settle_block();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_count();
    test_extremes();
    test_count_limits();
    test_ties();
    test_overflow();
    test_random_clouds(0, 0, 125);
    test_random_clouds(70, 0, 125);
    test_random_clouds(0, 70, 125);
    test_random_clouds(23, 23, 125);
    settle_block();
    $display("Streamed %0d points in %0d clouds and checked %0d sample indices.",
             points_sent, clouds_closed, results_seen);
    $display("Covered counts 0..127 with clamping, ties, store overflow and %s",
             "sender gaps and receiver stalls.");
    if (mismatches == 0 && expected_picks.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
